// ===== design/wapf_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the windowed average publish filter
// no dependencies
package wapf_pkg;

    localparam int DEPTH = 64;
    localparam int SMP_W = 16;
    localparam int CFG_W = 16;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = SMP_W + PTR_W;
    localparam int NUM_W = SUM_W + 1;
    localparam int DIVS_W = CNT_W + 1;
    localparam int STEP_W = $clog2(NUM_W);
    localparam int MS_W = 32;
    localparam int MS_PER_S = 1000;
    localparam int INT_MS_W = CFG_W + $clog2(MS_PER_S);

    localparam int MEASURE_RESET_S = 1;
    localparam int PUBLISH_RESET_S = 60;
    localparam int THRESHOLD_RESET = 1;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] CFG_MEASURE_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_PUBLISH_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_CHANGE_THRESHOLD = 2'd2;

    typedef struct packed {
        logic [1:0]              op;
        logic                    sample_ok;
        logic signed [SMP_W-1:0] sample_value;
    } in_word_t;

    typedef struct packed {
        logic                    measure_due;
        logic                    publish;
        logic                    last_ok;
        logic signed [SMP_W-1:0] last_value;
        logic                    average_ok;
        logic signed [SMP_W-1:0] average_value;
    } out_word_t;

    typedef struct packed {
        logic accept;
        logic sample_update;
        logic apply_other;
        logic div_init;
        logic div_step;
        logic div_end;
        logic decide;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       count_zero;
    } dp_status_t;

endpackage

// ===== design/wapf_ram.sv =====
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies
module wapf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/wapf_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine: sequences update, serial divide and publish decision
// depends on wapf_pkg
module wapf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_op,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  wapf_pkg::dp_status_t status,
    output wapf_pkg::ctrl_cmd_t  cmd
);
    import wapf_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_READ     = 3'd1;
    localparam logic [2:0] S_APPLY    = 3'd2;
    localparam logic [2:0] S_DIV_INIT = 3'd3;
    localparam logic [2:0] S_DIV      = 3'd4;
    localparam logic [2:0] S_DIV_END  = 3'd5;
    localparam logic [2:0] S_DECIDE   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              accept;
    logic              decide;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign decide    = (state_reg == S_DECIDE) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd               = '0;
        cmd.accept        = accept;
        cmd.sample_update = (state_reg == S_READ);
        cmd.apply_other   = (state_reg == S_APPLY);
        cmd.div_init      = (state_reg == S_DIV_INIT);
        cmd.div_step      = (state_reg == S_DIV);
        cmd.div_end       = (state_reg == S_DIV_END);
        cmd.decide        = decide;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_op == OP_SAMPLE) ? S_READ : S_APPLY;
                end
            end
            S_READ:
            begin
                state_next = S_DIV_INIT;
            end
            S_APPLY:
            begin
                state_next = S_DECIDE;
            end
            S_DIV_INIT:
            begin
                step_next  = '0;
                state_next = status.count_zero ? S_DECIDE : S_DIV;
            end
            S_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(NUM_W - 1))
                begin
                    state_next = S_DIV_END;
                end
            end
            S_DIV_END:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (decide)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (decide)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/wapf_dp.sv =====
`timescale 1ns / 1ps
// datapath: sample ring, running sum, serial divider, timers and publish record
// depends on wapf_pkg and wapf_ram
module wapf_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wapf_pkg::ctrl_cmd_t  cmd,
    output wapf_pkg::dp_status_t status,
    input  wapf_pkg::in_word_t   in_word,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [wapf_pkg::CFG_W-1:0] cfg_data,
    output wapf_pkg::out_word_t  out_word
);
    import wapf_pkg::*;

    in_word_t                item_reg;
    logic [PTR_W-1:0]        wp_reg;
    logic [PTR_W-1:0]        wp_inc;
    logic [DEPTH-1:0]        valid_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    last_ok_reg;
    logic signed [SMP_W-1:0] last_value_reg;
    logic signed [SMP_W-1:0] avg_reg;
    logic                    ever_meas_reg;
    logic [MS_W-1:0]         ms_meas_reg;
    logic                    ever_pub_reg;
    logic [MS_W-1:0]         ms_pub_reg;
    logic signed [SMP_W-1:0] pub_value_reg;
    logic signed [SMP_W-1:0] pub_avg_reg;
    logic [INT_MS_W-1:0]     meas_ms_reg;
    logic [INT_MS_W-1:0]     pub_ms_reg;
    logic [CFG_W-1:0]        thr_reg;
    logic [NUM_W-1:0]        dvd_reg;
    logic [DIVS_W-1:0]       rem_reg;
    out_word_t               out_reg;

    logic [SMP_W-1:0]        ram_rdata;
    logic                    ram_re;
    logic                    old_valid;
    logic signed [SMP_W-1:0] old_value;
    logic signed [SMP_W-1:0] new_value;
    logic signed [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0]        cnt_next;

    logic [SUM_W-1:0]        mag;
    logic [DIVS_W-1:0]       divisor;
    logic [DIVS_W:0]         shifted;
    logic                    ge;
    logic [DIVS_W-1:0]       diff;
    logic [SMP_W-1:0]        quot;

    logic                    aok;
    logic signed [SMP_W:0]   d_value;
    logic signed [SMP_W:0]   d_avg;
    logic [SMP_W:0]          abs_value;
    logic [SMP_W:0]          abs_avg;
    logic                    pub_due;
    logic                    pub;
    logic                    measure_due;

    assign wp_inc = (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign ram_re = cmd.accept && (in_word.op == OP_SAMPLE);

    wapf_ram #(
        .WIDTH (SMP_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.sample_update),
        .waddr (wp_reg),
        .wdata (new_value),
        .re    (ram_re),
        .raddr (wp_inc),
        .rdata (ram_rdata)
    );

    // entry leaving the window and entry coming in
    assign old_valid = valid_reg[wp_reg];
    assign old_value = old_valid ? $signed(ram_rdata) : '0;
    assign new_value = item_reg.sample_ok ? item_reg.sample_value : '0;
    assign sum_next  = sum_reg - {{(SUM_W-SMP_W){old_value[SMP_W-1]}}, old_value}
                     + {{(SUM_W-SMP_W){new_value[SMP_W-1]}}, new_value};
    assign cnt_next  = cnt_reg - CNT_W'(old_valid) + CNT_W'(item_reg.sample_ok);

    // restoring divider: (2*|sum| + n) / (2*n)
    assign mag     = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign divisor = {cnt_reg, 1'b0};
    assign shifted = {rem_reg, dvd_reg[NUM_W-1]};
    assign ge      = (shifted >= {1'b0, divisor});
    assign diff    = DIVS_W'(shifted - {1'b0, divisor});
    assign quot    = dvd_reg[SMP_W-1:0];

    // publish decision on state after the update
    assign aok       = (cnt_reg != '0);
    assign d_value   = {pub_value_reg[SMP_W-1], pub_value_reg}
                     - {last_value_reg[SMP_W-1], last_value_reg};
    assign d_avg     = {pub_avg_reg[SMP_W-1], pub_avg_reg} - {avg_reg[SMP_W-1], avg_reg};
    assign abs_value = d_value[SMP_W] ? (SMP_W+1)'(-d_value) : (SMP_W+1)'(d_value);
    assign abs_avg   = d_avg[SMP_W] ? (SMP_W+1)'(-d_avg) : (SMP_W+1)'(d_avg);
    assign pub_due   = (ms_pub_reg >= MS_W'(pub_ms_reg));

    always_comb
    begin
        pub = 1'b0;
        if (last_ok_reg)
        begin
            if (!ever_pub_reg)
            begin
                pub = 1'b1;
            end
            else if (pub_value_reg == last_value_reg)
            begin
                pub = pub_due;
            end
            else
            begin
                pub = (abs_value >= {1'b0, thr_reg})
                   || (aok && (abs_avg >= {1'b0, thr_reg}))
                   || (aok && (avg_reg == last_value_reg));
            end
        end
    end

    assign measure_due = !ever_meas_reg || (ms_meas_reg >= MS_W'(meas_ms_reg));

    assign status.count_zero = (cnt_reg == '0);
    assign out_word          = out_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            last_ok_reg   <= 1'b0;
            last_value_reg <= '0;
            avg_reg       <= '0;
            ever_meas_reg <= 1'b0;
            ms_meas_reg   <= '0;
            ever_pub_reg  <= 1'b0;
            ms_pub_reg    <= '0;
            pub_value_reg <= '0;
            pub_avg_reg   <= '0;
            meas_ms_reg   <= INT_MS_W'(MEASURE_RESET_S * MS_PER_S);
            pub_ms_reg    <= INT_MS_W'(PUBLISH_RESET_S * MS_PER_S);
            thr_reg       <= CFG_W'(THRESHOLD_RESET);
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MEASURE_INTERVAL:
                    begin
                        meas_ms_reg <= INT_MS_W'(cfg_data) * INT_MS_W'(MS_PER_S);
                    end
                    CFG_PUBLISH_INTERVAL:
                    begin
                        pub_ms_reg <= INT_MS_W'(cfg_data) * INT_MS_W'(MS_PER_S);
                    end
                    CFG_CHANGE_THRESHOLD:
                    begin
                        thr_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (ram_re)
            begin
                wp_reg <= wp_inc;
            end

            if (cmd.sample_update)
            begin
                valid_reg[wp_reg] <= item_reg.sample_ok;
                sum_reg           <= sum_next;
                cnt_reg           <= cnt_next;
                last_ok_reg       <= item_reg.sample_ok;
                last_value_reg    <= new_value;
                ever_meas_reg     <= 1'b1;
                ms_meas_reg       <= '0;
            end

            if (cmd.apply_other)
            begin
                case (item_reg.op)
                    OP_TICK:
                    begin
                        if (ms_meas_reg != '1)
                        begin
                            ms_meas_reg <= ms_meas_reg + 1'b1;
                        end
                        if (ms_pub_reg != '1)
                        begin
                            ms_pub_reg <= ms_pub_reg + 1'b1;
                        end
                    end
                    OP_CLEAR:
                    begin
                        valid_reg      <= '0;
                        sum_reg        <= '0;
                        cnt_reg        <= '0;
                        last_ok_reg    <= 1'b0;
                        last_value_reg <= '0;
                        avg_reg        <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.div_init && (cnt_reg == '0))
            begin
                avg_reg <= '0;
            end

            if (cmd.div_end)
            begin
                avg_reg <= sum_reg[SUM_W-1] ? $signed(-quot) : $signed(quot);
            end

            if (cmd.decide && pub)
            begin
                ever_pub_reg  <= 1'b1;
                ms_pub_reg    <= '0;
                pub_value_reg <= last_value_reg;
                pub_avg_reg   <= avg_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= in_word;
        end

        if (cmd.div_init)
        begin
            dvd_reg <= NUM_W'({mag, 1'b0}) + NUM_W'(cnt_reg);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff : shifted[DIVS_W-1:0];
        end

        if (cmd.decide)
        begin
            out_reg.measure_due   <= measure_due;
            out_reg.publish       <= pub;
            out_reg.last_ok       <= last_ok_reg;
            out_reg.last_value    <= last_value_reg;
            out_reg.average_ok    <= aok;
            out_reg.average_value <= avg_reg;
        end
    end

endmodule

// ===== design/windowed_average_publish_filter.sv =====
`timescale 1ns / 1ps
// top level of the windowed average publish filter
// depends on wapf_pkg, wapf_ctrl, wapf_dp
//
// Takes one word at a time: a 1 ms tick, a sensor sample, or a history clear,
// and returns one result word per input word. A tick, a clear or the unused
// op code goes through an apply step and then the decision. A sample goes
// through a window update, a divider load, a 23-step restoring divider that
// forms the rounded window average, a sign fixup and the decision (the
// divider and fixup are skipped when the window is empty). The input stays
// stalled until the decision, so the next word waits for it. The ring of 64
// samples sits in a RAM with one write and one read port and per-entry valid
// flops, so no clearing pass runs after reset or clear. A finished result
// waits in an output register, and the next input word is taken while it
// waits; a result held downstream delays the next decision. Configuration
// writes are always ready and must be issued only while the block is idle.
module windowed_average_publish_filter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  wapf_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output wapf_pkg::out_word_t out_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [wapf_pkg::CFG_W-1:0] cfg_data
);
    import wapf_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    wapf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_op     (in_word.op),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    wapf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_word   (in_word),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_word  (out_word)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while previous word still in work");

    a_avg_zero_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.average_ok |-> out_word.average_value == '0)
        else $error("average nonzero with empty window");

    a_publish_needs_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.publish |-> out_word.last_ok)
        else $error("publish without a valid latest sample");
`endif

endmodule
